>>> design/ppsc_pkg.sv
`default_nettype none
package ppsc_pkg;

  // Timer width; configuration fields are 16 bits regardless.
  localparam int TIMER_WIDTH = 16;
  localparam int CFG_W       = 16;
  localparam int APB_DATA_W  = 32;
  localparam int APB_ADDR_W  = 4;

  typedef logic [TIMER_WIDTH-1:0] timer_t;
  typedef logic [CFG_W-1:0]       cfg_word_t;

  localparam timer_t    TIMER_MAX          = '1;
  localparam cfg_word_t PULSE_WIDTH_RESET  = 16'd500;
  localparam cfg_word_t WAKE_DELAY_RESET   = 16'd500;
  localparam cfg_word_t COOLDOWN_RESET     = 16'd300;

  typedef enum logic [1:0] {
    REG_ENABLE      = 2'd0,
    REG_PULSE_WIDTH = 2'd1,
    REG_WAKE_DELAY  = 2'd2,
    REG_COOLDOWN    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_ENQ      = 3'd0,
    ST_INVALID  = 3'd1,
    ST_COOLDOWN = 3'd2,
    ST_BUSY     = 3'd3,
    ST_TICK     = 3'd4
  } status_t;

  typedef struct packed {
    logic      enable;
    cfg_word_t pulse_width;
    cfg_word_t wake_delay;
    cfg_word_t cooldown;
  } cfg_t;

  typedef struct packed {
    status_t status;
    logic    line_out;
    logic    busy_res;
    logic    done_res;
  } result_t;

  // Load a register value into a timer, saturating if the timer is narrower.
  function automatic timer_t timer_load(input cfg_word_t v);
    logic [CFG_W+TIMER_WIDTH-1:0] wide;
    logic [CFG_W+TIMER_WIDTH-1:0] lim;
    wide = (CFG_W+TIMER_WIDTH)'(v);
    lim  = (CFG_W+TIMER_WIDTH)'(TIMER_MAX);
    if (wide > lim) begin
      return TIMER_MAX;
    end
    return wide[TIMER_WIDTH-1:0];
  endfunction

endpackage
`default_nettype wire

>>> design/ppsc_req_if.sv
`default_nettype none
interface ppsc_req_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [2:0] pulse_count;

  modport source (output valid, action, pulse_count, input ready);
  modport sink   (input valid, action, pulse_count, output ready);
endinterface
`default_nettype wire

>>> design/ppsc_rsp_if.sv
`default_nettype none
interface ppsc_rsp_if;
  logic              valid;
  logic              ready;
  ppsc_pkg::status_t status;
  logic              line_out;
  logic              busy_res;
  logic              done_res;

  modport source (output valid, status, line_out, busy_res, done_res, input ready);
  modport sink   (input valid, status, line_out, busy_res, done_res, output ready);
endinterface
`default_nettype wire

>>> design/ppsc_cfg_regs.sv
`default_nettype none
module ppsc_cfg_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ppsc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ppsc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ppsc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready,
  output ppsc_pkg::cfg_t                       cfg
);

  ppsc_pkg::reg_idx_t idx;
  logic               wr;

  assign pready = 1'b1;
  assign idx    = ppsc_pkg::reg_idx_t'(paddr[3:2]);
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable      <= 1'b0;
      cfg.pulse_width <= ppsc_pkg::PULSE_WIDTH_RESET;
      cfg.wake_delay  <= ppsc_pkg::WAKE_DELAY_RESET;
      cfg.cooldown    <= ppsc_pkg::COOLDOWN_RESET;
    end else if (wr) begin
      case (idx)
        ppsc_pkg::REG_ENABLE:      cfg.enable      <= pwdata[0];
        ppsc_pkg::REG_PULSE_WIDTH: cfg.pulse_width <= pwdata[ppsc_pkg::CFG_W-1:0];
        ppsc_pkg::REG_WAKE_DELAY:  cfg.wake_delay  <= pwdata[ppsc_pkg::CFG_W-1:0];
        ppsc_pkg::REG_COOLDOWN:    cfg.cooldown    <= pwdata[ppsc_pkg::CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      ppsc_pkg::REG_ENABLE:      prdata = ppsc_pkg::APB_DATA_W'(cfg.enable);
      ppsc_pkg::REG_PULSE_WIDTH: prdata = ppsc_pkg::APB_DATA_W'(cfg.pulse_width);
      ppsc_pkg::REG_WAKE_DELAY:  prdata = ppsc_pkg::APB_DATA_W'(cfg.wake_delay);
      ppsc_pkg::REG_COOLDOWN:    prdata = ppsc_pkg::APB_DATA_W'(cfg.cooldown);
      default:                   prdata = '0;
    endcase
  end

endmodule
`default_nettype wire

>>> design/ppsc_seq.sv
`default_nettype none
module ppsc_seq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           fire,
  input  wire logic           action,
  input  wire logic [2:0]     pulse_count,
  input  ppsc_pkg::cfg_t      cfg,
  output ppsc_pkg::result_t   res
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_GAP  = 2'd2
  } phase_t;

  phase_t           phase, phase_next;
  ppsc_pkg::timer_t phase_timer, phase_timer_next;
  ppsc_pkg::timer_t cool_timer, cool_timer_next;
  logic             pend, pend_next;
  logic             count_ok;
  logic             timer_end;
  phase_t           phase_cur;

  assign count_ok  = (pulse_count == 3'd1) || (pulse_count == 3'd2);
  assign timer_end = (phase_timer <= ppsc_pkg::timer_t'(1));

  // Unreachable code 3 folds to idle.
  always_comb begin
    case (phase)
      PH_HIGH: phase_cur = PH_HIGH;
      PH_GAP:  phase_cur = PH_GAP;
      default: phase_cur = PH_IDLE;
    endcase
  end

  always_comb begin
    phase_next       = phase_cur;
    phase_timer_next = phase_timer;
    cool_timer_next  = cool_timer;
    pend_next        = pend;
    res.status       = ppsc_pkg::ST_TICK;
    res.done_res     = 1'b0;
    if (action) begin
      if (!cfg.enable) begin
        res.status = ppsc_pkg::ST_BUSY;
      end else if (!count_ok) begin
        res.status = ppsc_pkg::ST_INVALID;
      end else if (cool_timer != '0) begin
        res.status = ppsc_pkg::ST_COOLDOWN;
      end else if (phase_cur != PH_IDLE) begin
        res.status = ppsc_pkg::ST_BUSY;
      end else begin
        res.status       = ppsc_pkg::ST_ENQ;
        pend_next        = (pulse_count == 3'd2);
        phase_next       = PH_HIGH;
        phase_timer_next = ppsc_pkg::timer_load(cfg.pulse_width);
      end
    end else begin
      case (phase_cur)
        PH_HIGH: begin
          if (!timer_end) begin
            phase_timer_next = phase_timer - ppsc_pkg::timer_t'(1);
          end else if (pend) begin
            pend_next = 1'b0;
            if (cfg.wake_delay == '0) begin
              phase_timer_next = ppsc_pkg::timer_load(cfg.pulse_width);
            end else begin
              phase_next       = PH_GAP;
              phase_timer_next = ppsc_pkg::timer_load(cfg.wake_delay);
            end
          end else begin
            phase_next       = PH_IDLE;
            phase_timer_next = '0;
            cool_timer_next  = ppsc_pkg::timer_load(cfg.cooldown);
            res.done_res     = 1'b1;
          end
        end
        PH_GAP: begin
          if (timer_end) begin
            phase_next       = PH_HIGH;
            phase_timer_next = ppsc_pkg::timer_load(cfg.pulse_width);
          end else begin
            phase_timer_next = phase_timer - ppsc_pkg::timer_t'(1);
          end
        end
        default: begin
          if (cool_timer != '0) begin
            cool_timer_next = cool_timer - ppsc_pkg::timer_t'(1);
          end
        end
      endcase
    end
    res.line_out = (phase_next == PH_HIGH);
    res.busy_res = (phase_next != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      phase_timer <= '0;
      cool_timer  <= '0;
      pend        <= 1'b0;
    end else if (fire) begin
      phase       <= phase_next;
      phase_timer <= phase_timer_next;
      cool_timer  <= cool_timer_next;
      pend        <= pend_next;
    end
  end

  a_cool_only_idle: assert property (@(posedge clk) disable iff (rst)
    cool_timer != '0 |-> phase == PH_IDLE)
    else $error("cooldown running during a sequence");

  a_gap_no_pending: assert property (@(posedge clk) disable iff (rst)
    phase == PH_GAP |-> !pend)
    else $error("second pulse still pending in wake gap");

  a_enq_starts: assert property (@(posedge clk) disable iff (rst)
    fire && action && res.status == ppsc_pkg::ST_ENQ |=> phase == PH_HIGH)
    else $error("accepted request did not start a pulse");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    fire && res.done_res |=> phase == PH_IDLE && cool_timer == $past(cool_timer_next))
    else $error("completion without return to idle");

endmodule
`default_nettype wire

>>> design/pulse_pair_sequencer_with_cooldown_core.sv
`default_nettype none
// Channel   Dir   Beat payload                                  Handshake
// req       in    action, pulse_count                           valid/ready
// rsp       out   status, line_out, busy_res, done_res          valid/ready
// apb       in    enable, pulse_width, wake_delay, cooldown     psel/penable, pready=1
//
// One beat in, one beat out. A request beat is evaluated against the current
// sequencer state in the cycle it is taken and its result lands in the output
// register on the same edge; throughput is 1 beat/cycle while rsp.ready is high.
// The output register is the only stage: req.ready drops only while a result
// is held and rsp.ready is low. Synchronous reset clears sequencer state and
// the output valid; configuration returns to enable=0, 500/500/300 ticks.
module pulse_pair_sequencer_with_cooldown_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  ppsc_req_if.sink                             req,
  ppsc_rsp_if.source                           rsp,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ppsc_pkg::APB_ADDR_W-1:0] paddr,
  input  wire logic [ppsc_pkg::APB_DATA_W-1:0] pwdata,
  output logic      [ppsc_pkg::APB_DATA_W-1:0] prdata,
  output logic                                 pready
);

  ppsc_pkg::cfg_t    cfg;
  ppsc_pkg::result_t res;
  ppsc_pkg::result_t out_data;
  logic              out_valid;
  logic              fire;

  ppsc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Take a new beat whenever the output slot is free or being drained.
  assign req.ready = !out_valid || rsp.ready;
  assign fire      = req.valid && req.ready;

  ppsc_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .action      (req.action),
    .pulse_count (req.pulse_count),
    .cfg         (cfg),
    .res         (res)
  );

  // Output valid: set by an accepted beat, cleared once the result is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload, no reset needed.
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data <= res;
    end
  end

  assign rsp.valid    = out_valid;
  assign rsp.status   = out_data.status;
  assign rsp.line_out = out_data.line_out;
  assign rsp.busy_res = out_data.busy_res;
  assign rsp.done_res = out_data.done_res;

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |-> !fire)
    else $error("held result overwritten");

  a_fire_sets_valid: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("accepted beat produced no result");

  a_done_is_tick: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.status == ppsc_pkg::ST_TICK && !out_data.busy_res)
    else $error("completion flagged on a non-tick beat");

endmodule
`default_nettype wire
